// ===== rtl/atd_pkg.sv =====
// Shared types and constants for the accelerometer tap detector.
`timescale 1ns / 1ps

package atd_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START_THRESHOLD = 2'd0,
		REG_QUIET_THRESHOLD = 2'd1,
		REG_GAP_LIMIT       = 2'd2,
		REG_SHORT_LIMIT     = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned DIFF_W     = 13;
	localparam int unsigned QCNT_W     = 4;
	localparam int unsigned OUT_LEN_W  = 10;
	localparam int unsigned STRENGTH_W = 6;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [DIFF_W-1:0]     START_THRESHOLD_RST = 13'd20;
	localparam logic [DIFF_W-1:0]     QUIET_THRESHOLD_RST = 13'd12;
	localparam logic [QCNT_W-1:0]     GAP_LIMIT_RST       = 4'd5;
	localparam logic [OUT_LEN_W-1:0]  SHORT_LIMIT_RST     = 10'd30;

	// Strength is d / 10 capped at 60; at d >= 610 the cap applies.
	localparam logic [STRENGTH_W-1:0] STRENGTH_CAP    = 6'd60;
	localparam logic [DIFF_W-1:0]     STRENGTH_SAT_D  = 13'd610;
	// floor(x * 205 / 2048) equals x / 10 for every x below 1029.
	localparam logic [7:0]            DIV10_MUL       = 8'd205;
	localparam int unsigned           DIV10_SHIFT     = 11;

	localparam logic [QCNT_W-1:0]     QCNT_MAX        = 4'd15;
	localparam logic [OUT_LEN_W-1:0]  OUT_LEN_MAX     = 10'd1023;

	typedef struct packed {
		logic [DIFF_W-1:0]    start_threshold;
		logic [DIFF_W-1:0]    quiet_threshold;
		logic [QCNT_W-1:0]    gap_limit;
		logic [OUT_LEN_W-1:0] short_limit;
	} cfg_t;

	// Result item; fields are listed from the highest tdata bit down.
	typedef struct packed {
		logic                  short_tap;
		logic [STRENGTH_W-1:0] tap_strength;
		logic [OUT_LEN_W-1:0]  tap_length;
		logic                  tap_done;
		logic                  in_tap;
	} result_t;

endpackage

// ===== rtl/atd_step.sv =====
// Tap detector state and per-sample update logic.
`timescale 1ns / 1ps

module atd_step
	import atd_pkg::*;
#(
	parameter int LENGTH_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [15:0]    sample,
	input  cfg_t                  cfg,
	output result_t               result
);

	localparam int LW = (LENGTH_BITS + 1 > 11) ? LENGTH_BITS + 1 : 11;

	logic signed [15:0]       prev_q;
	logic                     have_prev_q;
	logic                     tapping_q;
	logic [QCNT_W-1:0]        qcnt_q;
	logic [LENGTH_BITS-1:0]   since_q;
	logic [STRENGTH_W-1:0]    strength_q;

	logic signed [16:0]       delta;
	logic [16:0]              abs_delta;
	logic [DIFF_W-1:0]        d;
	logic [17:0]              div_prod;
	logic [STRENGTH_W-1:0]    strength_new;

	logic                     tapping_d;
	logic [QCNT_W-1:0]        qcnt_d;
	logic [QCNT_W-1:0]        qcnt_inc;
	logic [LENGTH_BITS-1:0]   since_d;
	logic [LENGTH_BITS-1:0]   since_inc;
	logic [STRENGTH_W-1:0]    strength_d;
	logic                     done;
	logic [LW-1:0]            total;
	logic [LW-1:0]            qcnt_ext;
	logic [LW-1:0]            vib_len;
	logic [OUT_LEN_W-1:0]     length;

	always_comb begin
		delta     = {sample[15], sample} - {prev_q[15], prev_q};
		abs_delta = delta[16] ? 17'(-delta) : 17'(delta);
		d         = DIFF_W'(abs_delta >> 3);
		div_prod  = 18'(d[9:0]) * 18'(DIV10_MUL);
		strength_new = (d >= STRENGTH_SAT_D) ? STRENGTH_CAP
		                                    : div_prod[DIV10_SHIFT +: STRENGTH_W];
	end

	always_comb begin
		since_inc = (since_q != {LENGTH_BITS{1'b1}}) ? since_q + 1'b1 : since_q;
		qcnt_inc  = (qcnt_q != QCNT_MAX) ? qcnt_q + 1'b1 : qcnt_q;
		total     = LW'(since_inc) + 1'b1;
		qcnt_ext  = LW'(qcnt_inc);
		vib_len   = (total > qcnt_ext) ? total - qcnt_ext : '0;
		length    = (vib_len > LW'(OUT_LEN_MAX)) ? OUT_LEN_MAX : vib_len[OUT_LEN_W-1:0];

		tapping_d  = tapping_q;
		qcnt_d     = qcnt_q;
		since_d    = since_q;
		strength_d = strength_q;
		done       = 1'b0;
		if (have_prev_q) begin
			if (tapping_q) begin
				since_d = since_inc;
				if (d < cfg.quiet_threshold) begin
					qcnt_d = qcnt_inc;
					if (qcnt_inc > cfg.gap_limit) begin
						done      = 1'b1;
						tapping_d = 1'b0;
						qcnt_d    = '0;
					end
				end else begin
					qcnt_d = '0;
				end
			end else if (d >= cfg.start_threshold) begin
				strength_d = strength_new;
				since_d    = '0;
				qcnt_d     = '0;
				tapping_d  = 1'b1;
			end
		end
	end

	always_comb begin
		result.in_tap       = tapping_d;
		result.tap_done     = done;
		result.tap_length   = done ? length : '0;
		result.tap_strength = (tapping_d || done) ? strength_d : '0;
		result.short_tap    = done && (length < cfg.short_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			tapping_q   <= 1'b0;
			qcnt_q      <= '0;
			since_q     <= '0;
			strength_q  <= '0;
		end else if (en) begin
			prev_q      <= sample;
			have_prev_q <= 1'b1;
			tapping_q   <= tapping_d;
			qcnt_q      <= qcnt_d;
			since_q     <= since_d;
			strength_q  <= strength_d;
		end
	end

endmodule

// ===== rtl/accel_tap_detector.sv =====
// Top level of the accelerometer tap detector.
//
// Usage:
// Raw z samples enter on the s_axis channel, one item per sample, and every
// sample yields exactly one result item on the m_axis channel. An item is
// taken when tvalid and tready are both high at a rising edge of clk.
// The first item after reset only seeds the previous sample and reports
// no tap.
// A sample sits in the input register until it can advance; it then
// is evaluated against the detector state and lands in the output register.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// The detector state is updated as an item moves from the input register
// to the output register, so consecutive samples see each other's effect.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more; s_tready then drops until the
// output is taken. arst_n clears the state and loads the reset values of
// the configuration registers. Write configuration only while idle.
`timescale 1ns / 1ps

module accel_tap_detector
	import atd_pkg::*;
#(
	parameter int LENGTH_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_TDATA_W-1:0]   s_tdata,   // [15:0] sample
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [0] in_tap, [1] tap_done, [11:2] tap_length, [17:12] tap_strength,
	// [18] short_tap, [23:19] zero
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic signed [15:0] sample_s1;
	logic               out_valid_q;
	result_t            out_q;
	result_t            result;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_threshold <= START_THRESHOLD_RST;
			cfg_q.quiet_threshold <= QUIET_THRESHOLD_RST;
			cfg_q.gap_limit       <= GAP_LIMIT_RST;
			cfg_q.short_limit     <= SHORT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_THRESHOLD: cfg_q.start_threshold <= cfg_data;
				REG_QUIET_THRESHOLD: cfg_q.quiet_threshold <= cfg_data;
				REG_GAP_LIMIT:       cfg_q.gap_limit       <= cfg_data[QCNT_W-1:0];
				REG_SHORT_LIMIT:     cfg_q.short_limit     <= cfg_data[OUT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= signed'(s_tdata);
		end
	end

	atd_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_q};

endmodule

// ===== rtl/atd_checker.sv =====
// Port-level checks for the tap detector, bound to the top level.
`timescale 1ns / 1ps

module atd_port_checker
	import atd_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [OUT_TDATA_W-1:0]  m_tdata
);

	result_t res;
	assign res = m_tdata[$bits(result_t)-1:0];

	// A new result appears only after an input item was taken.
	a_result_follows_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result item without a preceding input item");

	// An ended tap leaves the detector idle.
	a_done_not_tapping: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.tap_done |-> !res.in_tap)
		else $error("tap_done with in_tap set");

	// Length and short flag are only meaningful together with tap_done.
	a_length_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.tap_done |-> (res.tap_length == '0) && !res.short_tap)
		else $error("tap_length or short_tap without tap_done");

	a_strength_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.tap_strength <= STRENGTH_CAP) &&
		             ((res.in_tap || res.tap_done) || (res.tap_strength == '0)))
		else $error("tap_strength out of range or set outside a tap");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

endmodule

bind accel_tap_detector atd_port_checker u_atd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
